// ===== design/rdc_pkg.sv =====
// Shared types, constants and helper functions for the radix display converter.
// Used by the accumulate and divide cells, the top level and the port checker.
package rdc_pkg;

    localparam int DIGITS    = 7;
    localparam int SYM_IN_W  = 8;
    localparam int SYM_OUT_W = 7;
    localparam int BASE_W    = 5;
    localparam int DIG_W     = 4;
    localparam int VAL_W     = DIG_W * DIGITS;
    localparam int POW_W     = VAL_W + 1;
    localparam int BIT_STEPS = DIG_W;
    localparam int STEP_W    = 2;
    localparam int NUM_DIV   = DIGITS * BIT_STEPS;

    localparam int IN_W      = DIGITS * SYM_IN_W + 2 * BASE_W;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = DIGITS * SYM_OUT_W + 1;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [STEP_W-1:0]   STEP_LAST = STEP_W'(BIT_STEPS - 1);
    localparam logic [BASE_W-1:0]   BASE_MIN  = 5'd2;
    localparam logic [BASE_W-1:0]   BASE_MAX  = 5'd16;
    localparam logic [SYM_OUT_W-1:0] CH_SPACE = 7'h20;
    localparam logic [SYM_OUT_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [SYM_OUT_W-1:0] CH_ALPHA = 7'h41;
    localparam logic [SYM_IN_W-1:0]  IN_ZERO  = 8'h30;
    localparam logic [SYM_IN_W-1:0]  IN_NINE  = 8'h39;
    localparam logic [SYM_IN_W-1:0]  IN_A     = 8'h41;
    localparam logic [SYM_IN_W-1:0]  IN_F     = 8'h46;

    typedef logic [DIG_W-1:0] digit_t;

    // Item travelling through the accumulate cells
    typedef struct packed {
        logic [DIGITS-1:0][SYM_IN_W-1:0] syms;   // index 0 is consumed next
        logic [BASE_W-1:0]               fb;
        logic [BASE_W-1:0]               tb;
        logic [VAL_W-1:0]                value;
        logic [DIGITS:0][POW_W-1:0]      pw;     // index 0 is the newest power
    } horner_t;

    // Item travelling through the divide cells
    typedef struct packed {
        logic [VAL_W-1:0]               rem;
        logic [VAL_W-1:0]               trial;
        logic [DIGITS-1:0][VAL_W-1:0]   pows;    // index 0 is the next divisor
        logic [DIGITS-1:0][DIG_W-1:0]   digs;    // finished digits, newest in 0
        digit_t                         cur;
        logic [STEP_W-1:0]              step;
        logic                           ovf;
    } div_t;

    function automatic digit_t sym_value(input logic [SYM_IN_W-1:0] sym);
        digit_t d;
        d = '0;
        if (sym >= IN_ZERO && sym <= IN_NINE) begin
            d = DIG_W'(sym - IN_ZERO);
        end else if (sym >= IN_A && sym <= IN_F) begin
            d = DIG_W'(sym - IN_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [SYM_OUT_W-1:0] digit_char(input digit_t d);
        logic [SYM_OUT_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + SYM_OUT_W'(d);
        end else begin
            c = CH_ALPHA + SYM_OUT_W'(d - 4'd10);
        end
        return c;
    endfunction

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

// ===== design/rdc_horner_cell.sv =====
// Accumulate cell: folds one input character into the running value and
// raises the target base power by one. Depends on rdc_pkg.
module rdc_horner_cell import rdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    ce,
    input  logic    in_valid,
    input  horner_t in_data,
    output logic    out_valid,
    output horner_t out_data
);

    logic                      valid_reg;
    horner_t                   data_reg;
    horner_t                   data_next;
    logic [VAL_W+BASE_W-1:0]   val_prod;
    logic [POW_W+BASE_W-1:0]   pow_prod;

    always_comb begin
        val_prod = in_data.value * in_data.fb;
        pow_prod = in_data.pw[0] * in_data.tb;
        data_next       = in_data;
        data_next.syms  = in_data.syms >> SYM_IN_W;
        // exact: the running value never exceeds VAL_W bits
        data_next.value = val_prod[VAL_W-1:0] + VAL_W'(sym_value(in_data.syms[0]));
        data_next.pw    = in_data.pw << POW_W;
        data_next.pw[0] = pow_prod[POW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/rdc_div_cell.sv =====
// Divide cell: settles one quotient bit of the current target digit by
// compare and subtract, and moves on to the next digit after the last bit.
// Depends on rdc_pkg.
module rdc_div_cell import rdc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic ce,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic   valid_reg;
    div_t   data_reg;
    div_t   data_next;
    logic   ge;
    digit_t cur_bits;

    always_comb begin
        ge        = in_data.rem >= in_data.trial;
        cur_bits  = {in_data.cur[DIG_W-2:0], ge};
        data_next = in_data;
        data_next.rem = ge ? in_data.rem - in_data.trial : in_data.rem;
        if (in_data.step == STEP_LAST) begin
            // digit done: store it and load the next power
            data_next.digs    = in_data.digs << DIG_W;
            data_next.digs[0] = cur_bits;
            data_next.cur     = '0;
            data_next.trial   = in_data.pows[0] << (BIT_STEPS - 1);
            data_next.pows    = in_data.pows >> VAL_W;
            data_next.step    = '0;
        end else begin
            data_next.cur   = cur_bits;
            data_next.trial = in_data.trial >> 1;
            data_next.step  = in_data.step + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/radix_display_converter.sv =====
// Top level of the radix display converter: accumulate chain, divide chain,
// character formatting and output skid stage. Depends on rdc_pkg and the cells.
//
// Takes one transfer of DIGITS characters and two bases per clock while
// s_tready is high, and returns one transfer of DIGITS right-justified
// characters and an overflow flag per item, in order. Throughput is one
// item every cycle while the skid register is empty. The chain holds one
// accumulate cell per input character, four compare-and-subtract cells per
// output digit, and the output register. While the output is stalled, a skid
// register takes the arriving item; the whole chain then holds, with s_tready
// low, until the skid register drains.
module radix_display_converter import rdc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // in_sym_0 .. in_sym_6 (8 bits each), from_base (5), to_base (5), zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_sym_0 .. out_sym_6 (7 bits each), overflow_error (1), zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic              ce;
    logic              h_valid [DIGITS+1];
    horner_t           h_data  [DIGITS+1];
    logic              d_valid [NUM_DIV+1];
    div_t              d_data  [NUM_DIV+1];

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic              sk_valid_reg;
    logic [OUT_W-1:0]  sk_data_reg;
    logic [OUT_W-1:0]  out_word;
    logic              take;
    logic              out_free;

    assign ce       = !sk_valid_reg;
    assign s_tready = ce;

    // Unpack the input transfer
    always_comb begin
        h_valid[0] = s_tvalid;
        h_data[0]  = '0;
        for (int i = 0; i < DIGITS; i++) begin
            h_data[0].syms[i] = s_tdata[i*SYM_IN_W +: SYM_IN_W];
        end
        h_data[0].fb    = clamp_base(s_tdata[DIGITS*SYM_IN_W +: BASE_W]);
        h_data[0].tb    = clamp_base(s_tdata[DIGITS*SYM_IN_W+BASE_W +: BASE_W]);
        h_data[0].pw[0] = POW_W'(1);
    end

    for (genvar g = 0; g < DIGITS; g++) begin : g_horner
        rdc_horner_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (h_valid[g]),
            .in_data   (h_data[g]),
            .out_valid (h_valid[g+1]),
            .out_data  (h_data[g+1])
        );
    end

    // Hand over to the divide chain: first divisor is tb^(DIGITS-1)
    always_comb begin
        d_valid[0]       = h_valid[DIGITS];
        d_data[0]        = '0;
        d_data[0].rem    = h_data[DIGITS].value;
        d_data[0].trial  = h_data[DIGITS].pw[1][VAL_W-1:0] << (BIT_STEPS - 1);
        for (int j = 0; j < DIGITS - 1; j++) begin
            d_data[0].pows[j] = h_data[DIGITS].pw[j+2][VAL_W-1:0];
        end
        d_data[0].ovf = {1'b0, h_data[DIGITS].value} >= h_data[DIGITS].pw[0];
    end

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        rdc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (d_valid[g]),
            .in_data   (d_data[g]),
            .out_valid (d_valid[g+1]),
            .out_data  (d_data[g+1])
        );
    end

    // Format: blank leading zeros (keep the last place), blank all on overflow
    always_comb begin
        logic   seen;
        digit_t d;
        seen     = 1'b0;
        out_word = '0;
        for (int i = 0; i < DIGITS; i++) begin
            d = d_data[NUM_DIV].digs[DIGITS-1-i];
            if (d_data[NUM_DIV].ovf) begin
                out_word[i*SYM_OUT_W +: SYM_OUT_W] = CH_SPACE;
            end else if (!seen && d == '0 && i < DIGITS - 1) begin
                out_word[i*SYM_OUT_W +: SYM_OUT_W] = CH_SPACE;
            end else begin
                out_word[i*SYM_OUT_W +: SYM_OUT_W] = digit_char(d);
                seen = 1'b1;
            end
        end
        out_word[OUT_W-1] = d_data[NUM_DIV].ovf;
    end

    assign take     = ce && d_valid[NUM_DIV];
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (sk_valid_reg) begin
                m_valid_reg  <= 1'b1;
                sk_valid_reg <= take;
            end else begin
                m_valid_reg  <= take;
            end
        end else if (take) begin
            // hold the arriving item while the output is stalled
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (sk_valid_reg) begin
                m_data_reg  <= sk_data_reg;
                sk_data_reg <= out_word;
            end else begin
                m_data_reg  <= out_word;
            end
        end else if (take) begin
            sk_data_reg <= out_word;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

endmodule

// ===== design/rdc_checker.sv =====
// Port-level checker for the radix display converter, bound to the top level.
// Depends on rdc_pkg.
module rdc_checker import rdc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic all_blank;
    logic [SYM_OUT_W-1:0] last_sym;

    always_comb begin
        all_blank = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (m_tdata[i*SYM_OUT_W +: SYM_OUT_W] != CH_SPACE) begin
                all_blank = 1'b0;
            end
        end
    end

    assign last_sym = m_tdata[(DIGITS-1)*SYM_OUT_W +: SYM_OUT_W];

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_ovf_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_W-1] |-> all_blank)
        else $error("overflow result not blanked");

    a_last_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OUT_W-1] |-> last_sym != CH_SPACE)
        else $error("last place blank without overflow");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> OUT_W) == '0)
        else $error("padding bits not zero");

endmodule

bind radix_display_converter rdc_checker u_rdc_checker (.*);

// ===== tb/sv/radix_display_converter_tb.sv =====
// Self-checking bench for radix_display_converter: directed and random numbers
// go in over the s_ stream, and each display is checked against a local predictor.
// Depends on rdc_pkg and the RTL of the converter only.
module radix_display_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rdc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int CALM_ITEMS    = 230;
    localparam logic [SYM_IN_W-1:0] IN_SPACE = 8'h20;

    typedef struct packed {
        logic [DIGITS-1:0][SYM_IN_W-1:0] syms;
        logic [BASE_W-1:0]               from_base;
        logic [BASE_W-1:0]               to_base;
    } number_t;

    typedef struct packed {
        logic [DIGITS-1:0][SYM_OUT_W-1:0] syms;
        logic                             overflow;
    } display_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    display_t pending_displays[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       sender_idle    = 1'b1;
    bit       receiver_idle  = 1'b1;

    radix_display_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("radix_display_converter test failed");
            $finish;
        end
    end

    // Weighted digit sum in the source base, then repeated division in the target base
    function automatic display_t predict_display(input number_t n);
        display_t                r;
        longint unsigned         fb, tb, value, limit, v, d;
        logic [SYM_IN_W-1:0]     c;
        int                      i;
        fb = n.from_base;
        tb = n.to_base;
        if (fb < 2) fb = 2; else if (fb > 16) fb = 16;
        if (tb < 2) tb = 2; else if (tb > 16) tb = 16;
        value = 0;
        for (i = 0; i < DIGITS; i++) begin
            c = n.syms[i];
            d = 0;
            if (c >= IN_ZERO && c <= IN_NINE) begin
                d = c - IN_ZERO;
            end else if (c >= IN_A && c <= IN_F) begin
                d = c - IN_A + 10;
            end
            value = value * fb + d;
        end
        limit = 1;
        for (i = 0; i < DIGITS; i++) limit = limit * tb;
        r.overflow = (value >= limit);
        if (r.overflow) begin
            for (i = 0; i < DIGITS; i++) r.syms[i] = CH_SPACE;
        end else begin
            v = value;
            for (i = DIGITS - 1; i >= 0; i--) begin
                d = v % tb;
                v = v / tb;
                r.syms[i] = (d < 10) ? SYM_OUT_W'(CH_ZERO + d) : SYM_OUT_W'(CH_ALPHA + d - 10);
            end
            // blank leading zeros but keep the rightmost character
            for (i = 0; i < DIGITS - 1 && r.syms[i] == CH_ZERO; i++) r.syms[i] = CH_SPACE;
        end
        return r;
    endfunction

    function automatic number_t from_text(input string txt, input int fb, input int tb);
        number_t n;
        int      i;
        for (i = 0; i < DIGITS; i++) n.syms[i] = txt[i];
        n.from_base = BASE_W'(fb);
        n.to_base   = BASE_W'(tb);
        return n;
    endfunction

    function automatic number_t random_number(input bit well_formed);
        number_t n;
        int      i, lead, dv;
        if (!well_formed) begin
            for (i = 0; i < DIGITS; i++) n.syms[i] = SYM_IN_W'($urandom_range(0, 255));
            n.from_base = BASE_W'($urandom_range(0, 31));
            n.to_base   = BASE_W'($urandom_range(0, 31));
            return n;
        end
        n.from_base = BASE_W'($urandom_range(2, 16));
        n.to_base   = BASE_W'($urandom_range(2, 16));
        lead = $urandom_range(0, DIGITS);
        for (i = 0; i < DIGITS; i++) begin
            if (i < lead || $urandom_range(0, 19) == 0) begin
                n.syms[i] = IN_SPACE;
            end else begin
                // now and then a digit from 0 to F, which may not be below the base
                dv = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, n.from_base - 1);
                n.syms[i] = (dv < 10) ? SYM_IN_W'(IN_ZERO + dv) : SYM_IN_W'(IN_A + dv - 10);
            end
        end
        return n;
    endfunction

    task automatic send_number(input number_t n);
        logic [S_TDATA_W-1:0] data;
        int                   i;
        data = '0;
        for (i = 0; i < DIGITS; i++) data[i*SYM_IN_W +: SYM_IN_W] = n.syms[i];
        data[DIGITS*SYM_IN_W +: BASE_W]          = n.from_base;
        data[DIGITS*SYM_IN_W + BASE_W +: BASE_W] = n.to_base;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        pending_displays.push_back(predict_display(n));
        if (sender_idle && $urandom_range(0, 5) == 0) begin
            // now and then drop valid and put junk on the bus
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom});
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end
    endtask

    // Receiver: stall in random bursts while allowed
    always begin
        @(negedge aclk);
        if (receiver_idle && $urandom_range(0, 6) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        display_t             want;
        logic [SYM_OUT_W-1:0] got;
        int                   i;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_displays.size() == 0) begin
                $error("result transfer with no number outstanding");
                mismatch_count++;
            end else begin
                want = pending_displays.pop_front();
                for (i = 0; i < DIGITS; i++) begin
                    got = m_tdata[i*SYM_OUT_W +: SYM_OUT_W];
                    if (got !== want.syms[i]) begin
                        $error("out_sym_%0d: expected %h, got %h", i, want.syms[i], got);
                        mismatch_count++;
                    end
                end
                if (m_tdata[DIGITS*SYM_OUT_W] !== want.overflow) begin
                    $error("overflow_error: expected %b, got %b",
                           want.overflow, m_tdata[DIGITS*SYM_OUT_W]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed_values;
        send_number(from_text("0000000", 10, 10));
        send_number(from_text("       ", 10, 16));
        send_number(from_text("0000001", 16, 2));
        send_number(from_text("FFFFFFF", 16, 16));
        send_number(from_text("FFFFFFF", 16, 2));
        send_number(from_text("1111111", 2, 2));
        send_number(from_text("9999999", 10, 10));
        send_number(from_text("9999999", 10, 9));
        // either side of the seven-digit limit in base ten
        send_number(from_text("098967F", 16, 10));
        send_number(from_text("0989680", 16, 10));
        send_number(from_text("1000000", 2, 16));
        send_number(from_text("9A9A9A9", 2, 10));
        send_number(from_text("1234567", 8, 16));
    endtask

    task automatic test_odd_characters;
        number_t n;
        send_number(from_text("abcdef!", 16, 10));
        send_number(from_text("/0:9@AG", 16, 10));
        send_number(from_text("1 2 3 4", 10, 3));
        n = from_text("0000000", 16, 16);
        n.syms = '1;
        send_number(n);
        n.syms = '0;
        send_number(n);
    endtask

    task automatic test_base_clamping;
        send_number(from_text("1010101", 0, 31));
        send_number(from_text("1234567", 17, 1));
        send_number(from_text("0000011", 31, 0));
        send_number(from_text("00000FF", 1, 17));
    endtask

    task automatic test_random_traffic(input int count);
        int k;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        for (k = 0; k < count; k++) send_number(random_number($urandom_range(0, 4) != 0));
    endtask

    task automatic test_back_to_back(input int count);
        int k;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        for (k = 0; k < count; k++) send_number(random_number($urandom_range(0, 4) != 0));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_values();
        test_odd_characters();
        test_base_clamping();
        test_random_traffic(RANDOM_ITEMS);
        test_back_to_back(CALM_ITEMS);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("radix_display_converter test passed");
        end else begin
            $display("radix_display_converter test failed");
        end
        $finish;
    end

endmodule
